>>> hdl/round_robin_slot_pool_macros.svh
// Assertion macros shared by the slot pool RTL.
`ifndef ROUND_ROBIN_SLOT_POOL_MACROS_SVH
`define ROUND_ROBIN_SLOT_POOL_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define RRSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define RRSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rrsp_pkg.sv
// Shared types and constants of the round robin slot pool.
`timescale 1ns / 1ps
`default_nettype none
package rrsp_pkg;

  localparam int CMD_W     = 2;
  localparam int SLOT_ID_W = 4;
  localparam int LEN_W     = 12;

  // Largest length the length field can carry
  localparam logic [LEN_W-1:0] LEN_FIELD_MAX = {LEN_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQ_WR  = 2'd0,
    CMD_COMMIT  = 2'd1,
    CMD_ACQ_RD  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  // Status of one scan step
  typedef struct packed {
    logic hit;   // a matching slot lies in this step's window
    logic last;  // this window reaches the end of the pool
  } scan_stat_t;

endpackage
`default_nettype wire

>>> hdl/rrsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rrsp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

>>> hdl/rrsp_scan.sv
// Round robin scan step: looks at a window of up to eight slots per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rrsp_scan #(
  parameter int SLOT_COUNT = 16
) (
  input  logic [SLOT_COUNT-1:0]              busy_i,
  input  logic [SLOT_COUNT-1:0]              nz_i,
  input  logic                               want_data_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]      base_i,
  input  logic [$clog2(SLOT_COUNT+1)-1:0]    exam_i,
  output rrsp_pkg::scan_stat_t               stat_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      idx_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      next_base_o,
  output logic [$clog2(SLOT_COUNT+1)-1:0]    next_exam_o
);
  import rrsp_pkg::*;

  localparam int IW    = $clog2(SLOT_COUNT);
  localparam int CW    = $clog2(SLOT_COUNT + 1);
  localparam int LANES = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;
  localparam logic [IW:0] SC = (IW + 1)'(SLOT_COUNT);

  logic [IW-1:0]    cand [LANES];
  logic [LANES-1:0] lane_hit;

  // Slot of each lane, wrapped around the pool
  always_comb begin
    logic [IW:0] sum;
    for (int k = 0; k < LANES; k++) begin
      sum = {1'b0, base_i} + (IW + 1)'(k);
      if (sum >= SC) begin
        sum = sum - SC;
      end
      cand[k] = sum[IW-1:0];
      lane_hit[k] = ((32'(exam_i) + k) < SLOT_COUNT) &&
                    (want_data_i ? (busy_i[cand[k]] && nz_i[cand[k]])
                                 : !busy_i[cand[k]]);
    end
  end

  // Pick the first matching lane
  always_comb begin
    stat_o.hit = 1'b0;
    idx_o      = cand[0];
    for (int k = LANES - 1; k >= 0; k--) begin
      if (lane_hit[k]) begin
        stat_o.hit = 1'b1;
        idx_o      = cand[k];
      end
    end
    stat_o.last = (32'(exam_i) + LANES) >= SLOT_COUNT;
  end

  // Advance the window
  always_comb begin
    logic [IW:0] nsum;
    nsum = {1'b0, base_i} + (IW + 1)'(LANES);
    if (nsum >= SC) begin
      nsum = nsum - SC;
    end
    next_base_o = nsum[IW-1:0];
    next_exam_o = exam_i + CW'(LANES);
  end

endmodule
`default_nettype wire

>>> hdl/round_robin_slot_pool.sv
// Top level of the round robin slot pool: command sequencer, flags and length memory.
//
//  channel | dir | handshake              | fields
//  in      | in  | in_valid_i / in_stall_o | command_i, slot_id_i, commit_length_i
//  out     | out | out_valid_o / out_stall_i | out_found_o, out_granted_slot_o,
//          |     |                        | out_slot_length_o
//
// Each word passes the idle and exec states; a release of a slot in the pool and an
// acquire-read that finds a slot add the read state for the registered length memory
// read, and an acquire moves the eight-slot scan window over the flag vectors in exec.
// Reset clears busy and nonzero-length flags and both pointers at once; no clearing pass.
// A finished word waits in the output register while the next word is accepted.
// One word is worked on at a time, so the length memory needs no forwarding.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_slot_pool #(
  parameter int SLOT_COUNT = 16,
  parameter int SLOT_BYTES = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rrsp_pkg::CMD_W-1:0]      command_i,
  input  logic [rrsp_pkg::SLOT_ID_W-1:0]  slot_id_i,
  input  logic [rrsp_pkg::LEN_W-1:0]      commit_length_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            out_found_o,
  output logic [rrsp_pkg::SLOT_ID_W-1:0]  out_granted_slot_o,
  output logic [rrsp_pkg::LEN_W-1:0]      out_slot_length_o
);
  import rrsp_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [LEN_W-1:0] LEN_CAP =
    (SLOT_BYTES < int'(LEN_FIELD_MAX)) ? LEN_W'(SLOT_BYTES) : LEN_FIELD_MAX;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [SLOT_COUNT-1:0] nz_q, nz_d;
  logic [IW-1:0]         fill_ptr_q, fill_ptr_d;
  logic [IW-1:0]         drain_ptr_q, drain_ptr_d;
  logic                  out_valid_q, out_valid_d;

  cmd_e                  cmd_q, cmd_d;
  logic [SLOT_ID_W-1:0]  sid_q, sid_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [IW-1:0]         base_q, base_d;
  logic [CW-1:0]         exam_q, exam_d;
  logic [IW-1:0]         slot_q, slot_d;

  logic                  out_found_q, out_found_d;
  logic [SLOT_ID_W-1:0]  out_slot_q, out_slot_d;
  logic [LEN_W-1:0]      out_len_q, out_len_d;
  logic                  res_load;

  scan_stat_t            scan_stat;
  logic [IW-1:0]         scan_idx, scan_next_base, idx_inc;
  logic [CW-1:0]         scan_next_exam;

  logic                  ram_wr_en, ram_rd_en;
  logic [IW-1:0]         ram_rd_addr;
  logic [LEN_W-1:0]      ram_rd_data;

  logic                  out_free, sid_ok, wr_grant;
  logic [IW-1:0]         sid_idx;
  logic [LEN_W-1:0]      sat_len;

  rrsp_scan #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_scan (
    .busy_i      (busy_q),
    .nz_i        (nz_q),
    .want_data_i (cmd_q == CMD_ACQ_RD),
    .base_i      (base_q),
    .exam_i      (exam_q),
    .stat_o      (scan_stat),
    .idx_o       (scan_idx),
    .next_base_o (scan_next_base),
    .next_exam_o (scan_next_exam)
  );

  rrsp_ram #(
    .WIDTH(LEN_W),
    .DEPTH(SLOT_COUNT)
  ) u_len_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (sid_idx),
    .wr_data_i (sat_len),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Helper terms
  assign out_free = !out_valid_q || !out_stall_i;
  assign sid_ok   = 32'(sid_q) < SLOT_COUNT;
  assign sid_idx  = IW'(sid_q);
  assign sat_len  = (len_q > LEN_CAP) ? LEN_CAP : len_q;
  assign idx_inc  = (scan_idx == IW'(SLOT_COUNT - 1)) ? '0 : scan_idx + 1'b1;
  assign wr_grant = (state_q == ST_EXEC) && (cmd_q == CMD_ACQ_WR) && scan_stat.hit && out_free;

  // Command sequencer
  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    nz_d        = nz_q;
    fill_ptr_d  = fill_ptr_q;
    drain_ptr_d = drain_ptr_q;
    cmd_d       = cmd_q;
    sid_d       = sid_q;
    len_d       = len_q;
    base_d      = base_q;
    exam_d      = exam_q;
    slot_d      = slot_q;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = sid_idx;
    res_load    = 1'b0;
    out_found_d = 1'b0;
    out_slot_d  = '0;
    out_len_d   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(command_i);
          sid_d   = slot_id_i;
          len_d   = commit_length_i;
          base_d  = (cmd_e'(command_i) == CMD_ACQ_RD) ? drain_ptr_q : fill_ptr_q;
          exam_d  = '0;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (cmd_q == CMD_ACQ_WR || cmd_q == CMD_ACQ_RD) begin
          if (scan_stat.hit) begin
            if (cmd_q == CMD_ACQ_WR) begin
              // claim the free slot, its length reads as zero from now on
              if (wr_grant) begin
                busy_d[scan_idx] = 1'b1;
                nz_d[scan_idx]   = 1'b0;
                fill_ptr_d       = idx_inc;
                res_load         = 1'b1;
                out_found_d      = 1'b1;
                out_slot_d       = SLOT_ID_W'(scan_idx);
                state_d          = ST_IDLE;
              end
            end else begin
              // fetch the stored length of the ready slot
              drain_ptr_d = idx_inc;
              ram_rd_en   = 1'b1;
              ram_rd_addr = scan_idx;
              slot_d      = scan_idx;
              state_d     = ST_READ;
            end
          end else if (scan_stat.last) begin
            if (out_free) begin
              res_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end else begin
            base_d = scan_next_base;
            exam_d = scan_next_exam;
          end
        end else if (!sid_ok) begin
          // slot beyond the pool: drop the command
          if (out_free) begin
            res_load   = 1'b1;
            out_slot_d = sid_q;
            state_d    = ST_IDLE;
          end
        end else if (cmd_q == CMD_COMMIT) begin
          if (out_free) begin
            ram_wr_en     = 1'b1;
            nz_d[sid_idx] = (sat_len != '0);
            res_load      = 1'b1;
            out_found_d   = 1'b1;
            out_slot_d    = sid_q;
            out_len_d     = sat_len;
            state_d       = ST_IDLE;
          end
        end else begin
          // release: free the slot, then report its stored length
          busy_d[sid_idx] = 1'b0;
          ram_rd_en       = 1'b1;
          slot_d          = sid_idx;
          state_d         = ST_READ;
        end
      end

      ST_READ: begin
        if (out_free) begin
          res_load    = 1'b1;
          out_found_d = 1'b1;
          out_slot_d  = SLOT_ID_W'(slot_q);
          out_len_d   = nz_q[slot_q] ? ram_rd_data : '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      nz_q        <= '0;
      fill_ptr_q  <= '0;
      drain_ptr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      nz_q        <= nz_d;
      fill_ptr_q  <= fill_ptr_d;
      drain_ptr_q <= drain_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    sid_q  <= sid_d;
    len_q  <= len_d;
    base_q <= base_d;
    exam_q <= exam_d;
    slot_q <= slot_d;
    if (res_load) begin
      out_found_q <= out_found_d;
      out_slot_q  <= out_slot_d;
      out_len_q   <= out_len_d;
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_found_o        = out_found_q;
  assign out_granted_slot_o = out_slot_q;
  assign out_slot_length_o  = out_len_q;

`include "round_robin_slot_pool_macros.svh"

  `RRSP_ASSERT_NEXT(a_grant_marks_busy, wr_grant, busy_q[$past(scan_idx)], "granted slot not busy")
  `RRSP_ASSERT_NOW(a_scan_in_pool, state_q == ST_EXEC, 32'(exam_q) < SLOT_COUNT, "scan ran past pool")
  `RRSP_ASSERT_NOW(a_ptrs_in_pool, 1'b1, (32'(fill_ptr_q) < SLOT_COUNT) && (32'(drain_ptr_q) < SLOT_COUNT), "pointer out of pool")

endmodule
`default_nettype wire
